@@ rtl/clipped_rectangle_fill_unit_defines.svh @@
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_unit_defines.svh
// Assertion macros shared by the clipped rectangle fill unit.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_RECTANGLE_FILL_UNIT_DEFINES_SVH
`define CLIPPED_RECTANGLE_FILL_UNIT_DEFINES_SVH

// same-cycle implication
`define CRF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crf assertion failed");

// next-cycle implication
`define CRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crf assertion failed");

`endif

@@ rtl/crf_pkg.sv @@
// ----------------------------------------------------------------------------
// crf_pkg
// Types and constants of the clipped rectangle fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

    localparam int CmdDepth = 2;
    localparam int CmdPtrW  = $clog2(CmdDepth);
    localparam int CmdCntW  = CmdPtrW + 1;

    localparam int CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_WIDTH    = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 8'd3;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [10:0] width;
        logic [6:0]  height;
    } crf_cfg_t;

    // one clipped request, ready for row generation
    typedef struct packed {
        logic [15:0] base;
        logic [10:0] len;
        logic [6:0]  rows;
        logic [10:0] stride;
        logic [31:0] color;
    } crf_cmd_t;

endpackage

`default_nettype wire

@@ rtl/crf_front.sv @@
// ----------------------------------------------------------------------------
// crf_front
// Accepts fill requests, clips them against the strip buffer, drops the
// invisible ones and forms a row command with its starting pixel index.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_front #(
    parameter int MAX_BUFFER_WIDTH = 1024,
    parameter int MAX_STRIP_ROWS   = 64
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  crf_pkg::crf_cfg_t       cfg,
    input  wire                     push,
    output logic                    full,
    input  wire signed [12:0]       rect_x,
    input  wire signed [12:0]       rect_y,
    input  wire        [11:0]       rect_width,
    input  wire        [11:0]       rect_height,
    input  wire        [31:0]       fill_color,
    output logic                    cmd_valid,
    output crf_pkg::crf_cmd_t       cmd,
    input  wire                     cmd_ready
);
    import crf_pkg::*;

    logic [10:0]        tw_c;
    logic [6:0]         th_c;
    logic signed [14:0] rx, ry, rx_end, ry_end;
    logic signed [14:0] tx, ty, tx_end, ty_end;
    logic signed [14:0] vx, vy, vx_end, vy_end;
    logic               visible;
    logic               accept;
    logic [16:0]        row_prod;

    logic               s1_valid_reg, s1_valid_next;
    logic [10:0]        s1_col_reg;
    logic [5:0]         s1_row_reg;
    logic [10:0]        s1_len_reg;
    logic [6:0]         s1_rows_reg;
    logic [10:0]        s1_stride_reg;
    logic [31:0]        s1_color_reg;

    assign tw_c = ({2'b00, cfg.width} > 13'(MAX_BUFFER_WIDTH)) ?
                  11'(MAX_BUFFER_WIDTH) : cfg.width;
    assign th_c = ({1'b0, cfg.height} > 8'(MAX_STRIP_ROWS)) ?
                  7'(MAX_STRIP_ROWS) : cfg.height;

    assign rx     = {{2{rect_x[12]}}, rect_x};
    assign ry     = {{2{rect_y[12]}}, rect_y};
    assign rx_end = rx + $signed({3'b000, rect_width});
    assign ry_end = ry + $signed({3'b000, rect_height});
    assign tx     = $signed({3'b000, cfg.origin_x});
    assign ty     = $signed({3'b000, cfg.origin_y});
    assign tx_end = tx + $signed({4'b0000, tw_c});
    assign ty_end = ty + $signed({8'b0, th_c});

    assign vx     = (rx > tx) ? rx : tx;
    assign vy     = (ry > ty) ? ry : ty;
    assign vx_end = (rx_end < tx_end) ? rx_end : tx_end;
    assign vy_end = (ry_end < ty_end) ? ry_end : ty_end;

    assign visible = (rect_width != 12'd0) && (rect_height != 12'd0) &&
                     (tw_c != 11'd0) && (th_c != 7'd0) &&
                     (rx < tx_end) && (ry < ty_end) &&
                     (rx_end > tx) && (ry_end > ty);

    assign full   = s1_valid_reg && !cmd_ready;
    assign accept = push && !full;

    always_comb
    begin
        if (accept)
            s1_valid_next = visible;
        else if (cmd_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= 11'(vx - tx);
            s1_row_reg    <= 6'(vy - ty);
            s1_len_reg    <= 11'(vx_end - vx);
            s1_rows_reg   <= 7'(vy_end - vy);
            s1_stride_reg <= tw_c;
            s1_color_reg  <= fill_color;
        end
    end

    // start of the first visible row
    assign row_prod = 17'(s1_row_reg) * 17'(s1_stride_reg);

    assign cmd_valid  = s1_valid_reg;
    assign cmd.base   = 16'(row_prod) + 16'(s1_col_reg);
    assign cmd.len    = s1_len_reg;
    assign cmd.rows   = s1_rows_reg;
    assign cmd.stride = s1_stride_reg;
    assign cmd.color  = s1_color_reg;

endmodule

`default_nettype wire

@@ rtl/crf_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// crf_cmd_fifo
// Short command queue between the clipping front and the span back.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_cmd_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  crf_pkg::crf_cmd_t   wr_data,
    output logic                rd_valid,
    input  wire                 rd_ready,
    output crf_pkg::crf_cmd_t   rd_data
);
    import crf_pkg::*;

    crf_cmd_t             mem_reg [CmdDepth];
    logic [CmdPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CmdPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CmdCntW-1:0]   count_reg, count_next;
    logic                 do_wr, do_rd;

    assign wr_ready = (count_reg != CmdCntW'(CmdDepth));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

@@ rtl/crf_back.sv @@
// ----------------------------------------------------------------------------
// crf_back
// Walks the visible rows of a command, one span per cycle while the output
// is empty or popped, into an output register read as a queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  crf_pkg::crf_cmd_t   cmd,
    output logic                empty,
    input  wire                 pop,
    output logic [15:0]         span_start,
    output logic [10:0]         span_length,
    output logic [31:0]         span_color,
    output logic                last_span
);
    import crf_pkg::*;

    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] base_reg;
    logic [10:0] len_reg;
    logic [6:0]  rows_left_reg;
    logic [10:0] stride_reg;
    logic [31:0] color_reg;
    logic        gen, last_row, take;

    assign gen       = active_reg && (!out_valid_reg || pop);
    assign last_row  = (rows_left_reg == 7'd1);
    assign cmd_ready = !active_reg || (gen && last_row);
    assign take      = cmd_valid && cmd_ready;
    assign empty     = !out_valid_reg;

    always_comb
    begin
        active_next = active_reg;
        if (take)
            active_next = 1'b1;
        else if (gen && last_row)
            active_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (gen)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            span_start  <= base_reg;
            span_length <= len_reg;
            span_color  <= color_reg;
            last_span   <= last_row;
        end
        if (take)
        begin
            base_reg      <= cmd.base;
            len_reg       <= cmd.len;
            rows_left_reg <= cmd.rows;
            stride_reg    <= cmd.stride;
            color_reg     <= cmd.color;
        end
        else if (gen)
        begin
            base_reg      <= base_reg + 16'(stride_reg);
            rows_left_reg <= rows_left_reg - 7'd1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clipped_rectangle_fill_unit.sv @@
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_unit
// Clips fill rectangles against a strip buffer and emits one span per row.
// ----------------------------------------------------------------------------
// A request is clipped in one front stage and queued as a row command; the
// back emits one span per clock while its output is empty or popped, one per
// visible row (1 to 64, the strip height), and requests with no visible
// pixel are dropped by the front and emit nothing. The span generator's walk
// sets the sustained rate; a span passes the front stage register, command
// queue, back command registers and output register. Configuration writes
// are always ready and take effect on the next request.
`default_nettype none

module clipped_rectangle_fill_unit #(
    parameter int MAX_BUFFER_WIDTH = 1024,
    parameter int MAX_STRIP_ROWS   = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  wire signed [12:0]   rect_x,
    input  wire signed [12:0]   rect_y,
    input  wire        [11:0]   rect_width,
    input  wire        [11:0]   rect_height,
    input  wire        [31:0]   fill_color,
    output logic                empty,
    input  wire                 pop,
    output logic [15:0]         span_start,
    output logic [10:0]         span_length,
    output logic [31:0]         span_color,
    output logic                last_span,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [7:0]          cfg_index,
    input  wire  [31:0]         cfg_data
);
    import crf_pkg::*;

    crf_cfg_t cfg_reg, cfg_next;
    logic     front_valid, front_ready;
    crf_cmd_t front_cmd;
    logic     cmd_valid, cmd_ready;
    crf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: cfg_next.origin_x = cfg_data[11:0];
                REG_ORIGIN_Y: cfg_next.origin_y = cfg_data[11:0];
                REG_WIDTH:    cfg_next.width    = cfg_data[10:0];
                REG_HEIGHT:   cfg_next.height   = cfg_data[6:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= 12'd0;
            cfg_reg.origin_y <= 12'd0;
            cfg_reg.width    <= 11'd1024;
            cfg_reg.height   <= 7'd64;
        end
        else
            cfg_reg <= cfg_next;
    end

    crf_front #(
        .MAX_BUFFER_WIDTH (MAX_BUFFER_WIDTH),
        .MAX_STRIP_ROWS   (MAX_STRIP_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_color  (fill_color),
        .cmd_valid   (front_valid),
        .cmd         (front_cmd),
        .cmd_ready   (front_ready)
    );

    crf_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_cmd),
        .rd_valid (cmd_valid),
        .rd_ready (cmd_ready),
        .rd_data  (cmd)
    );

    crf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .empty       (empty),
        .pop         (pop),
        .span_start  (span_start),
        .span_length (span_length),
        .span_color  (span_color),
        .last_span   (last_span)
    );

`include "clipped_rectangle_fill_unit_defines.svh"

    `CRF_ASSERT_IMPLIES(a_span_nonzero, clk, rst_n, !empty, span_length != 11'd0)
    `CRF_ASSERT_IMPLIES(a_full_queue, clk, rst_n, full, front_valid && !front_ready)
    `CRF_ASSERT_NEXT(a_rows_continue, clk, rst_n, !empty && pop && !last_span, !empty)

endmodule

`default_nettype wire
